// ===== rtl/c2p_pkg.sv =====
// Package for the conserved-to-primitive gas state converter.
// Holds payload structs, register indexes and width constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package c2p_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int GAMMA_W = 19;
    localparam int FLOOR_W = 17;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd43691;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 17'd1;
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 8'd1;

    typedef struct packed {
        logic signed [WORD_BITS_DEF-1:0] mass_density;
        logic signed [WORD_BITS_DEF-1:0] momentum_x;
        logic signed [WORD_BITS_DEF-1:0] momentum_y;
        logic signed [WORD_BITS_DEF-1:0] momentum_z;
        logic signed [WORD_BITS_DEF-1:0] total_energy;
    } t_cons;

    typedef struct packed {
        logic [WORD_BITS_DEF-2:0]        density_out;
        logic signed [WORD_BITS_DEF-1:0] velocity_x;
        logic signed [WORD_BITS_DEF-1:0] velocity_y;
        logic signed [WORD_BITS_DEF-1:0] velocity_z;
        logic [WORD_BITS_DEF-2:0]        pressure;
        logic                            bad_density;
    } t_prim;
endpackage
`default_nettype wire

// ===== rtl/c2p_div_stage.sv =====
// One radix-2 restoring step of an unsigned pipelined divider.
// Standalone; used by c2p_divider.
`timescale 1ns / 1ps
`default_nettype none
module c2p_div_stage #(
    parameter int NW = 48,
    parameter int DW = 33
) (
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic [DW-1:0]      o_rem,
    output logic [NW-1:0]      o_num
);
    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    // shift in next numerator bit, subtract if it fits
    assign w_trial = {i_rem, i_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign o_rem   = w_diff[DW] ? w_trial[DW-1:0] : w_diff[DW-1:0];
    assign o_num   = {i_num[NW-2:0], ~w_diff[DW]};
endmodule
`default_nettype wire

// ===== rtl/c2p_divider.sv =====
// Pipelined unsigned divider, STEPS quotient bits per register stage.
// Depends on c2p_div_stage.
`timescale 1ns / 1ps
`default_nettype none
module c2p_divider #(
    parameter int NW = 48,
    parameter int DW = 33,
    parameter int STEPS = 4,
    parameter int TW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic [TW-1:0]      o_tag
);
    localparam int NST = (NW + STEPS - 1) / STEPS;

    logic                  r_vld [NST];
    logic [DW-1:0]         r_rem [NST];
    logic [NW-1:0]         r_num [NST];
    logic [DW-1:0]         r_den [NST];
    logic [TW-1:0]         r_tag [NST];

    genvar s, k;
    generate
        for (s = 0; s < NST; s++) begin : g_st
            logic          w_vin;
            logic [DW-1:0] w_din;
            logic [TW-1:0] w_tin;
            logic [DW-1:0] w_rem [STEPS+1];
            logic [NW-1:0] w_num [STEPS+1];
            // take the ports into the first stage, the previous stage otherwise
            if (s == 0) begin : g_first
                assign w_vin    = i_valid;
                assign w_rem[0] = '0;
                assign w_num[0] = i_num;
                assign w_din    = i_den;
                assign w_tin    = i_tag;
            end else begin : g_next
                assign w_vin    = r_vld[s-1];
                assign w_rem[0] = r_rem[s-1];
                assign w_num[0] = r_num[s-1];
                assign w_din    = r_den[s-1];
                assign w_tin    = r_tag[s-1];
            end
            for (k = 0; k < STEPS; k++) begin : g_k
                if (s * STEPS + k < NW) begin : g_real
                    c2p_div_stage #(.NW(NW), .DW(DW)) u_step (
                        .i_rem(w_rem[k]), .i_num(w_num[k]), .i_den(w_din),
                        .o_rem(w_rem[k+1]), .o_num(w_num[k+1]));
                end else begin : g_pad
                    assign w_rem[k+1] = w_rem[k];
                    assign w_num[k+1] = w_num[k];
                end
            end
            // advance stage valid and data
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= w_vin;
                end
                r_rem[s] <= w_rem[STEPS];
                r_num[s] <= w_num[STEPS];
                r_den[s] <= w_din;
                r_tag[s] <= w_tin;
            end
        end
    endgenerate

    assign o_valid = r_vld[NST-1];
    assign o_quo   = r_num[NST-1];
    assign o_tag   = r_tag[NST-1];
endmodule
`default_nettype wire

// ===== rtl/conserved_to_primitive_gas_state.sv =====
// Top level of the conserved-to-primitive gas state converter.
// Depends on c2p_pkg and c2p_divider (which uses c2p_div_stage).
//
// One cell enters per clock whenever i_start is high; o_busy stays low, so
// a new cell can follow every cycle. Each result appears on o_result for one
// cycle with o_done high, after three input stages (magnitudes, squares, sum
// of squares), then 17 stages of the four pipelined dividers (velocities and
// kinetic energy, 4 quotient bits per stage over 2*WORD_BITS+2 numerator
// bits), then two stages (velocity saturation and internal energy, then the
// gamma multiply and pressure limits). The receiver cannot stall and need not:
// nothing holds results back. Configuration writes are always accepted and
// take effect for cells that start afterwards.
`timescale 1ns / 1ps
`default_nettype none
module conserved_to_primitive_gas_state
    import c2p_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire t_cons                i_cell,
    output logic                      o_done,
    output t_prim                     o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);
    localparam int W = WORD_BITS_DEF;
    localparam int SQW = 2 * W + 2;       // sum of three squares
    localparam int NW  = SQW;             // shared divider numerator width
    localparam int DW  = W + 2;           // 2*rho fits
    localparam int TW  = 1 + 3 + GAMMA_W + FLOOR_W + (W - 1) + 1 + W;

    // configuration registers
    logic [GAMMA_W-1:0] r_gamma;
    logic [FLOOR_W-1:0] r_floor;
    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
            r_floor <= FLOOR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_GAMMA) r_gamma <= i_cfg_data[GAMMA_W-1:0];
            if (i_cfg_index == REG_FLOOR) r_floor <= i_cfg_data[FLOOR_W-1:0];
        end
    end

    // stage 1: magnitudes, signs, bad flag
    logic               r1_v, r1_bad;
    logic [W-1:0]       r1_rho;
    logic [W-1:0]       r1_am [3];
    logic [2:0]         r1_neg;
    logic signed [W-1:0] r1_e;
    logic [GAMMA_W-1:0] r1_g;
    logic [FLOOR_W-1:0] r1_f;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_start;
        r1_bad <= (i_cell.mass_density <= 0);
        r1_rho <= W'(i_cell.mass_density);
        r1_neg <= {i_cell.momentum_z[W-1], i_cell.momentum_y[W-1],
                   i_cell.momentum_x[W-1]};
        r1_am[0] <= i_cell.momentum_x[W-1] ? W'(-i_cell.momentum_x) : W'(i_cell.momentum_x);
        r1_am[1] <= i_cell.momentum_y[W-1] ? W'(-i_cell.momentum_y) : W'(i_cell.momentum_y);
        r1_am[2] <= i_cell.momentum_z[W-1] ? W'(-i_cell.momentum_z) : W'(i_cell.momentum_z);
        r1_e <= W'(i_cell.total_energy);
        r1_g <= r_gamma;
        r1_f <= r_floor;
    end

    // stage 2: squares
    logic               r2_v, r2_bad;
    logic [W-1:0]       r2_rho;
    logic [W-1:0]       r2_am [3];
    logic [2*W-1:0]     r2_sq [3];
    logic [2:0]         r2_neg;
    logic signed [W-1:0] r2_e;
    logic [GAMMA_W-1:0] r2_g;
    logic [FLOOR_W-1:0] r2_f;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_bad <= r1_bad; r2_rho <= r1_rho; r2_neg <= r1_neg;
        r2_e <= r1_e; r2_g <= r1_g; r2_f <= r1_f;
        for (int j = 0; j < 3; j++) begin
            r2_am[j] <= r1_am[j];
            r2_sq[j] <= r1_am[j] * r1_am[j];
        end
    end

    // stage 3: sum of squares
    logic               r3_v;
    logic [SQW-1:0]     r3_sum;
    logic [TW-1:0]      r3_tag;
    logic [W-1:0]       r3_am [3];
    logic [W-1:0]       r3_rho;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_sum <= SQW'(r2_sq[0]) + SQW'(r2_sq[1]) + SQW'(r2_sq[2]);
        r3_am  <= r2_am;
        r3_rho <= r2_rho;
        r3_tag <= {r2_bad, r2_neg, r2_g, r2_f, r2_rho[W-2:0], 1'b0, r2_e};
    end

    // dividers: three velocities and kinetic energy
    logic [NW-1:0] w_q [4];
    logic [3:0]    w_dv;
    logic [TW-1:0] w_tag [4];
    genvar d;
    generate
        for (d = 0; d < 4; d++) begin : g_div
            logic [NW-1:0] w_num;
            logic [DW-1:0] w_den;
            if (d < 3) begin : g_vel
                assign w_num = NW'({r3_am[d], FRAC_BITS'(0)});
                assign w_den = DW'(r3_rho);
            end else begin : g_kin
                assign w_num = NW'(r3_sum);
                assign w_den = DW'({r3_rho, 1'b0});
            end
            c2p_divider #(.NW(NW), .DW(DW), .STEPS(4), .TW(TW)) u_div (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r3_v),
                .i_num(w_num), .i_den(w_den), .i_tag(r3_tag),
                .o_valid(w_dv[d]), .o_quo(w_q[d]), .o_tag(w_tag[d]));
        end
    endgenerate

    // unpack carried fields
    logic               t_bad;
    logic [2:0]         t_neg;
    logic [GAMMA_W-1:0] t_g;
    logic [FLOOR_W-1:0] t_f;
    logic [W-2:0]       t_rho;
    logic               t_pad;
    logic signed [W-1:0] t_e;
    assign {t_bad, t_neg, t_g, t_f, t_rho, t_pad, t_e} = w_tag[0];

    // stage A: saturate velocities, internal energy
    localparam logic [W:0] VMAXP = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0] VMAXN = {2'b01, {(W-1){1'b0}}};
    logic                r4_v, r4_bad;
    logic [W-1:0]        r4_vel [3];
    logic signed [W+1:0] r4_int;
    logic [GAMMA_W-1:0]  r4_g;
    logic [FLOOR_W-1:0]  r4_f;
    logic [W-2:0]        r4_rho;
    logic [NW:0]         w_kin;
    always_comb begin
        w_kin = (w_q[3] > NW'({1'b1, W'(0)})) ? (NW+1)'({1'b1, W'(0)}) : {1'b0, w_q[3]};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= w_dv[0];
        r4_bad <= t_bad; r4_g <= t_g; r4_f <= t_f; r4_rho <= t_rho;
        for (int j = 0; j < 3; j++) begin
            if (t_neg[j]) begin
                r4_vel[j] <= (w_q[j] >= NW'(VMAXN)) ? {1'b1, {(W-1){1'b0}}}
                                                      : W'(-w_q[j]);
            end else begin
                r4_vel[j] <= (w_q[j] >= NW'(VMAXP)) ? {1'b0, {(W-1){1'b1}}}
                                                      : W'(w_q[j]);
            end
        end
        r4_int <= (W+2)'(t_e) - $signed({1'b0, w_kin[W:0]});
    end

    // stage B: gamma multiply, floor, saturate
    localparam int PW = W + 2 + GAMMA_W;
    logic            r5_v;
    t_prim           r5_res;
    logic [PW-1:0]   w_prod;
    logic [PW-1:0]   w_p;
    logic [W-2:0]    w_pres;
    always_comb begin
        w_prod = (r4_int > 0) ? PW'(r4_g) * PW'(r4_int[W:0]) : '0;
        w_p    = w_prod >> FRAC_BITS;
        w_pres = (w_p > PW'({(W-1){1'b1}})) ? {(W-1){1'b1}} : (W-1)'(w_p);
        if (w_pres < (W-1)'(r4_f)) w_pres = (W-1)'(r4_f);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r4_v;
        if (r4_bad) begin
            r5_res <= '{density_out: '0, velocity_x: '0, velocity_y: '0,
                        velocity_z: '0, pressure: '0, bad_density: 1'b1};
        end else begin
            r5_res.density_out <= r4_rho;
            r5_res.velocity_x  <= r4_vel[0];
            r5_res.velocity_y  <= r4_vel[1];
            r5_res.velocity_z  <= r4_vel[2];
            r5_res.pressure    <= w_pres;
            r5_res.bad_density <= 1'b0;
        end
    end

    assign o_done   = r5_v;
    assign o_result = r5_res;

    logic w_unused;
    assign w_unused = t_pad ^ (|w_dv[3:1]) ^ (|w_tag[1]) ^ (|w_tag[2]) ^ (|w_tag[3])
                      ^ (|r3_sum[0]);

    // checks
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.bad_density |-> o_result.pressure == '0)
        else $error("bad density with nonzero pressure");
    a_good_pres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.bad_density && r_floor != '0 |-> o_result.pressure != '0)
        else $error("pressure below floor");
    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv[0] == w_dv[3])
        else $error("divider lanes out of step");
endmodule
`default_nettype wire

// ===== dv/tb_conserved_to_primitive_gas_state.sv =====
// Self-checking testbench for conserved_to_primitive_gas_state.
// Depends on c2p_pkg. An in-bench predictor computes each primitive state from
// the accepted cell; a scoreboard checks the results in order.
`timescale 1ns / 1ps

module tb_conserved_to_primitive_gas_state
    import c2p_pkg::*;
();

    localparam int LATENCY   = 40;
    localparam int MAX_CYCLE = 400000;
    localparam longint WMAX  = 64'sd2147483647;
    localparam longint WMIN  = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 8'd5;

    // Predicts primitive states and holds them until the block returns them
    class prim_scoreboard;
        t_prim                  pending_q[$];
        logic [GAMMA_W-1:0]     gamma_m1;
        logic [FLOOR_W-1:0]     p_floor;
        int                     errors;

        function new();
            gamma_m1 = GAMMA_RESET;
            p_floor  = FLOOR_RESET;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == REG_GAMMA) gamma_m1 = data[GAMMA_W-1:0];
            else if (idx == REG_FLOOR) p_floor = data[FLOOR_W-1:0];
        endfunction

        function longint clamp_word(longint v);
            if (v > WMAX) return WMAX;
            if (v < WMIN) return WMIN;
            return v;
        endfunction

        function t_prim to_primitive(t_cons c);
            t_prim             r;
            longint            rho, mom, vel, internal, pres;
            longint unsigned   mag, sumsq, kin, prod;
            logic signed [31:0] m [3];
            r = '0;
            rho = longint'(c.mass_density);
            m[0] = c.momentum_x;
            m[1] = c.momentum_y;
            m[2] = c.momentum_z;
            if (rho <= 0) begin
                r.bad_density = 1'b1;
                return r;
            end
            sumsq = 0;
            for (int i = 0; i < 3; i++) begin
                mom = longint'(m[i]);
                vel = clamp_word((mom * 65536) / rho);
                if (i == 0) r.velocity_x = vel[31:0];
                else if (i == 1) r.velocity_y = vel[31:0];
                else r.velocity_z = vel[31:0];
                mag = (mom < 0) ? longint'(-mom) : longint'(mom);
                sumsq += mag * mag;
            end
            kin = sumsq / (2 * longint'(rho));
            if (kin > 64'd4294967296) kin = 64'd4294967296;
            internal = longint'(c.total_energy) - longint'(kin);
            pres = 0;
            if (internal > 0) begin
                prod = longint'(gamma_m1) * longint'(internal);
                pres = longint'(prod >> 16);
                if (pres > WMAX) pres = WMAX;
            end
            if (pres < longint'(p_floor)) pres = longint'(p_floor);
            if (pres > WMAX) pres = WMAX;
            r.density_out = rho[30:0];
            r.pressure    = pres[30:0];
            return r;
        endfunction

        function void note_cell(t_cons c);
            pending_q.push_back(to_primitive(c));
        endfunction

        function void check_result(t_prim got);
            t_prim want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.density_out !== want.density_out || got.velocity_x !== want.velocity_x ||
                got.velocity_y !== want.velocity_y || got.velocity_z !== want.velocity_z ||
                got.pressure !== want.pressure || got.bad_density !== want.bad_density) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: rho exp %h got %h,", want.density_out,
                             got.density_out,
                             " v exp %h %h %h got %h %h %h,", want.velocity_x,
                             want.velocity_y, want.velocity_z, got.velocity_x,
                             got.velocity_y, got.velocity_z,
                             " p exp %h got %h, bad exp %b got %b", want.pressure,
                             got.pressure, want.bad_density, got.bad_density);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_cons                i_cell;
    logic                 o_done;
    t_prim                o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    prim_scoreboard sb = new();
    int             cycle_cnt = 0;
    bit             gaps_on = 1;

    conserved_to_primitive_gas_state dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cell      (i_cell),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Generate the clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Note accepted cells and check returned beats
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) sb.note_cell(i_cell);
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == MAX_CYCLE) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Send one cell; hold start high when more follow without a gap
    task automatic send_cell(t_cons c);
        int gap;
        i_start <= 1'b1;
        i_cell  <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pause_start();
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for all outstanding beats, then let the pipeline empty
    task automatic drain();
        pause_start();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_cons make_cell(logic signed [31:0] rho, logic signed [31:0] mx,
                                        logic signed [31:0] my, logic signed [31:0] mz,
                                        logic signed [31:0] e);
        t_cons c;
        c.mass_density = rho;
        c.momentum_x   = mx;
        c.momentum_y   = my;
        c.momentum_z   = mz;
        c.total_energy = e;
        return c;
    endfunction

    // Random cell: mostly physical (positive density, scaled values), some raw noise or nonpositive density
    function automatic t_cons rand_cell();
        t_cons c;
        int    sh;
        c = make_cell($urandom, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 9))
            0, 1: ;
            2: c.mass_density = -$signed($urandom_range(0, 1000));
            default: begin
                sh = $urandom_range(0, 30);
                c.mass_density = ($urandom >> sh) | 32'd1;
                c.mass_density[31] = 1'b0;
                c.momentum_x = $signed(c.momentum_x) >>> $urandom_range(0, 31);
                c.momentum_y = $signed(c.momentum_y) >>> $urandom_range(0, 31);
                c.momentum_z = $signed(c.momentum_z) >>> $urandom_range(0, 31);
                if ($urandom_range(0, 2) != 0) c.total_energy[31] = 1'b0;
                c.total_energy = $signed(c.total_energy) >>> $urandom_range(0, 20);
            end
        endcase
        return c;
    endfunction

    task automatic directed_cells();
        send_cell(make_cell(32'sd0, 32'sd65536, 32'sd1, -32'sd1, 32'sd100000));
        send_cell(make_cell(-32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1));
        send_cell(make_cell(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0,
                            32'sh7fff_ffff));
        send_cell(make_cell(32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, 32'sh7fff_ffff));
        send_cell(make_cell(32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sh7fff_ffff));
        send_cell(make_cell(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                            32'sh7fff_ffff));
        send_cell(make_cell(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000));
        send_cell(make_cell(32'sd65536, 32'sd65536, -32'sd65536, 32'sd0, 32'sd65536));
        send_cell(make_cell(32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        send_cell(make_cell(32'sd65536, 32'sd0, 32'sd0, 32'sd0, -32'sd1));
        send_cell(make_cell(32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd1));
        send_cell(make_cell(32'sd2, 32'sd1, 32'sd1, 32'sd1, 32'sd1));
        send_cell(make_cell(32'sd1, -32'sd32768, 32'sd32767, 32'sd32768, 32'sh4000_0000));
    endtask

    task automatic random_cells(int n);
        for (int k = 0; k < n; k++) send_cell(rand_cell());
    endtask

    // Main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_cell      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values first
        directed_cells();
        random_cells(250);
        drain();

        // Only the top bit set in gamma and floor
        write_reg(REG_GAMMA, 32'd262144);
        write_reg(REG_FLOOR, 32'd65536);
        directed_cells();
        random_cells(250);
        drain();

        // Smallest listed values, plus a write to an unlisted index
        write_reg(REG_GAMMA, 32'd1);
        write_reg(REG_FLOOR, 32'd1);
        write_reg(REG_UNLISTED, 32'hffff_ffff);
        random_cells(250);
        drain();

        // Zero registers, full-width data with upper bits set
        write_reg(REG_GAMMA, 32'hfff8_0000);
        write_reg(REG_FLOOR, 32'hfffe_0000);
        directed_cells();
        random_cells(250);
        drain();

        // All register bits high
        write_reg(REG_GAMMA, 32'hffff_ffff);
        write_reg(REG_FLOOR, 32'hffff_ffff);
        random_cells(200);
        drain();

        // Random settings, no idling at the end
        write_reg(REG_GAMMA, $urandom_range(1, 262144));
        write_reg(REG_FLOOR, $urandom_range(1, 65536));
        random_cells(150);
        gaps_on = 0;
        random_cells(250);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
